@@ hdl/fqc_pkg.sv @@
`timescale 1ns / 1ps
// package for the fifo queue with cursor: sizes, mode codes, transaction types
// no dependencies
package fqc_pkg;

  // queue depth and derived widths
  localparam int unsigned DEPTH = 16;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned DATA_W = 32;
  localparam int unsigned MODE_W = 3;

  // operation codes
  localparam logic [MODE_W-1:0] MODE_PUSH   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_POP    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_CRESET = 3'd2;
  localparam logic [MODE_W-1:0] MODE_CADV   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CREAD  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd5;

  // input transaction
  typedef struct packed {
    logic [MODE_W-1:0]        mode;
    logic signed [DATA_W-1:0] data_in;
  } fqc_req_t;

  // result transaction
  typedef struct packed {
    logic                     ok;
    logic signed [DATA_W-1:0] data_out;
    logic [CNT_W-1:0]         fill_count;
    logic                     cursor_ok;
  } fqc_rsp_t;

  // per-cell control
  typedef struct packed {
    logic load;
    logic shift;
  } fqc_cell_ctrl_t;

endpackage

@@ hdl/fqc_cell.sv @@
`timescale 1ns / 1ps
// one storage cell of the compacting queue chain
// depends on fqc_pkg
module fqc_cell (
  input  logic                             clk_i,
  input  fqc_pkg::fqc_cell_ctrl_t          ctrl_i,
  input  logic signed [fqc_pkg::DATA_W-1:0] push_data_i,
  input  logic signed [fqc_pkg::DATA_W-1:0] next_data_i,
  output logic signed [fqc_pkg::DATA_W-1:0] data_o
);
  import fqc_pkg::*;

  logic signed [DATA_W-1:0] data_q;
  logic signed [DATA_W-1:0] data_d;

  // take the neighbor's word on a shift, the pushed word on a load
  always_comb begin
    data_d = data_q;
    if (ctrl_i.shift) begin
      data_d = next_data_i;
    end else if (ctrl_i.load) begin
      data_d = push_data_i;
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

@@ hdl/fifo_queue_with_cursor.sv @@
`timescale 1ns / 1ps
// top level of the fifo queue with cursor: control, cell chain, result register
// depends on fqc_pkg and fqc_cell
//
// Usage: one input channel (in_valid_i / in_stall_o / in_req_i) carries an
// operation code and a push value; one output channel (out_valid_o /
// out_stall_i / out_rsp_o) returns exactly one result per accepted transaction.
// Entries sit compacted in a row of DEPTH cells, head in cell 0. A pop or a
// remove at the cursor shifts all later cells down by one in the same cycle.
// The result is registered and appears on out_rsp_o in the cycle after acceptance.
// Throughput: one transaction per cycle while no result waits under out_stall_i,
// set by the cell shift and the registered result stage.
// The result register is the only buffer: while a result waits under
// out_stall_i the input is stalled, and it is accepted again in the cycle
// the waiting result is taken.
// Reset (rst_ni low, asynchronous) empties the queue, invalidates the cursor
// and drops any pending result; cell contents are left as they are and are
// never read before being written by a push.
module fifo_queue_with_cursor (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  fqc_pkg::fqc_req_t in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output fqc_pkg::fqc_rsp_t out_rsp_o
);
  import fqc_pkg::*;

  logic [CNT_W-1:0] held_q, held_d;
  logic [IDX_W-1:0] pos_q, pos_d;
  logic             live_q, live_d;
  logic             out_valid_q;
  fqc_rsp_t         rsp_q, rsp_d;

  logic                     fire;
  logic                     live_eff;
  logic                     empty;
  logic                     full;
  logic                     load_en;
  logic                     shift_en;
  logic [IDX_W-1:0]         shift_base;
  logic                     ok;
  logic signed [DATA_W-1:0] result;
  logic signed [DATA_W-1:0] cur_data;

  logic signed [DATA_W-1:0] slot [DEPTH];
  fqc_cell_ctrl_t           cell_ctrl [DEPTH];

  // handshake
  assign in_stall_o  = out_valid_q && out_stall_i;
  assign fire        = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

  // queue status
  assign live_eff = live_q && (CNT_W'(pos_q) < held_q);
  assign empty    = (held_q == '0);
  assign full     = (held_q == CNT_W'(DEPTH));
  assign cur_data = slot[pos_q];

  // operation decode
  always_comb begin
    held_d     = held_q;
    pos_d      = pos_q;
    live_d     = live_eff;
    load_en    = 1'b0;
    shift_en   = 1'b0;
    shift_base = '0;
    ok         = 1'b0;
    result     = '0;
    case (in_req_i.mode)
      MODE_PUSH: begin
        if (!full) begin
          load_en = 1'b1;
          held_d  = held_q + CNT_W'(1);
          ok      = 1'b1;
        end
      end
      MODE_POP: begin
        if (!empty) begin
          result   = slot[0];
          shift_en = 1'b1;
          held_d   = held_q - CNT_W'(1);
          if (live_eff) begin
            if (pos_q == '0) begin
              live_d = 1'b0;
            end else begin
              pos_d = pos_q - IDX_W'(1);
            end
          end
          ok = 1'b1;
        end
      end
      MODE_CRESET: begin
        if (!empty) begin
          pos_d  = '0;
          live_d = 1'b1;
          ok     = 1'b1;
        end
      end
      MODE_CADV: begin
        if (live_eff) begin
          if ((CNT_W'(pos_q) + CNT_W'(1)) < held_q) begin
            pos_d = pos_q + IDX_W'(1);
          end
          ok = 1'b1;
        end
      end
      MODE_CREAD: begin
        if (live_eff) begin
          result = cur_data;
          ok     = 1'b1;
        end
      end
      MODE_REMOVE: begin
        if (live_eff) begin
          result     = cur_data;
          shift_en   = 1'b1;
          shift_base = pos_q;
          held_d     = held_q - CNT_W'(1);
          if (CNT_W'(pos_q) >= (held_q - CNT_W'(1))) begin
            live_d = 1'b0;
          end
          ok = 1'b1;
        end
      end
      default: begin
      end
    endcase
    rsp_d.ok         = ok;
    rsp_d.data_out   = result;
    rsp_d.fill_count = held_d;
    rsp_d.cursor_ok  = live_d;
  end

  // cell chain: each cell loads on push at the tail or takes its neighbor on a shift
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DATA_W-1:0] next_data;

    if (i == DEPTH - 1) begin : g_last
      assign next_data = '0;
    end else begin : g_mid
      assign next_data = slot[i+1];
    end

    assign cell_ctrl[i].load  = fire && load_en && (CNT_W'(i) == held_q);
    assign cell_ctrl[i].shift = fire && shift_en && (IDX_W'(i) >= shift_base)
                                && ((CNT_W'(i) + CNT_W'(1)) < held_q);

    fqc_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (cell_ctrl[i]),
      .push_data_i (in_req_i.data_in),
      .next_data_i (next_data),
      .data_o      (slot[i])
    );
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= '0;
      pos_q       <= '0;
      live_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        held_q      <= held_d;
        pos_q       <= pos_d;
        live_q      <= live_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (fire) begin
      rsp_q <= rsp_d;
    end
  end

  // count never exceeds the depth
  assert property (@(posedge clk_i) disable iff (!rst_ni) held_q <= CNT_W'(DEPTH))
    else $error("fill count above depth");

  // a live cursor always points at a held entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    live_q |-> (CNT_W'(pos_q) < held_q))
    else $error("cursor points past the tail");

  // push into a full queue reports failure and keeps the count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && in_req_i.mode == MODE_PUSH && full)
    |=> (!out_rsp_o.ok && out_rsp_o.fill_count == CNT_W'(DEPTH)))
    else $error("push into full queue misreported");

  // pop of a non-empty queue drops the count by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && in_req_i.mode == MODE_POP && !empty)
    |=> (out_rsp_o.ok && held_q == $past(held_q) - CNT_W'(1)))
    else $error("pop count mismatch");

  // a result never overwrites a waiting one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !fire)
    else $error("input taken while result stalled");

endmodule

@@ bench/tb_fifo_queue_with_cursor.sv @@
`timescale 1ns / 1ps
// testbench for the fifo queue with cursor: directed and random operations checked
// against a shadow queue with cursor; depends on fqc_pkg and fifo_queue_with_cursor
module tb_fifo_queue_with_cursor;
  import fqc_pkg::*;

  // mode codes without a meaning in the block
  localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;
  localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7fff_ffff;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  fqc_req_t in_req_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  fqc_rsp_t out_rsp_o;

  // shadow of the queue contents and cursor
  logic signed [DATA_W-1:0] shadow_cells [DEPTH];
  logic [CNT_W-1:0]         shadow_fill = '0;
  logic [IDX_W-1:0]         shadow_cur = '0;
  logic                     shadow_cur_live = 1'b0;

  fqc_rsp_t pending_results [$];
  int       mismatch_count = 0;
  int       send_idle_pct = 14;
  int       recv_stall_pct = 14;
  int       recv_hold_left = 0;

  fifo_queue_with_cursor uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

  always #5 clk_i = ~clk_i;

  // ends the run if the block hangs
  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // drop one cell and close the gap behind it
  function automatic void shadow_close_gap(logic [IDX_W-1:0] pos);
    for (int i = pos; i + 1 < shadow_fill; i++) begin
      shadow_cells[i] = shadow_cells[i + 1];
    end
    shadow_fill = shadow_fill - 1'b1;
  endfunction

  // apply one operation to the shadow queue and return the expected result
  function automatic fqc_rsp_t apply_queue_op(fqc_req_t req);
    fqc_rsp_t rsp;
    rsp = '0;
    if (shadow_cur_live && CNT_W'(shadow_cur) >= shadow_fill) shadow_cur_live = 1'b0;
    case (req.mode)
      MODE_PUSH: begin
        if (shadow_fill < DEPTH) begin
          shadow_cells[shadow_fill[IDX_W-1:0]] = req.data_in;
          shadow_fill = shadow_fill + 1'b1;
          rsp.ok = 1'b1;
        end
      end
      MODE_POP: begin
        if (shadow_fill > 0) begin
          rsp.data_out = shadow_cells[0];
          shadow_close_gap('0);
          if (shadow_cur_live) begin
            if (shadow_cur == '0) shadow_cur_live = 1'b0;
            else shadow_cur = shadow_cur - 1'b1;
          end
          rsp.ok = 1'b1;
        end
      end
      MODE_CRESET: begin
        if (shadow_fill > 0) begin
          shadow_cur = '0;
          shadow_cur_live = 1'b1;
          rsp.ok = 1'b1;
        end
      end
      MODE_CADV: begin
        if (shadow_cur_live) begin
          if (CNT_W'(shadow_cur) + 1'b1 < shadow_fill) shadow_cur = shadow_cur + 1'b1;
          rsp.ok = 1'b1;
        end
      end
      MODE_CREAD: begin
        if (shadow_cur_live) begin
          rsp.data_out = shadow_cells[shadow_cur];
          rsp.ok = 1'b1;
        end
      end
      MODE_REMOVE: begin
        if (shadow_cur_live) begin
          rsp.data_out = shadow_cells[shadow_cur];
          shadow_close_gap(shadow_cur);
          if (CNT_W'(shadow_cur) >= shadow_fill) shadow_cur_live = 1'b0;
          rsp.ok = 1'b1;
        end
      end
      default: begin
      end
    endcase
    rsp.fill_count = shadow_fill;
    rsp.cursor_ok = shadow_cur_live;
    return rsp;
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // offer one transaction, with a random gap first, and log its expected result
  task automatic send_item(fqc_req_t req);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i <= req;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(apply_queue_op(req));
  endtask

  task automatic send_op(logic [MODE_W-1:0] mode, logic signed [DATA_W-1:0] value);
    fqc_req_t req;
    req.mode = mode;
    req.data_in = value;
    send_item(req);
  endtask

  // stop offering and wait for every outstanding result
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // random value, with the extremes mixed in
  function automatic logic signed [DATA_W-1:0] random_word();
    case ($urandom_range(0, 15))
      0: return WORD_MIN;
      1: return WORD_MAX;
      2: return '0;
      3: return -1;
      default: return $urandom;
    endcase
  endfunction

  // random operation with a given share of pushes
  function automatic logic [MODE_W-1:0] random_mode(int push_pct);
    int pick;
    if ($urandom_range(0, 99) < push_pct) return MODE_PUSH;
    pick = $urandom_range(0, 99);
    if (pick < 20) return MODE_POP;
    if (pick < 33) return MODE_CRESET;
    if (pick < 63) return MODE_CADV;
    if (pick < 78) return MODE_CREAD;
    if (pick < 94) return MODE_REMOVE;
    return $urandom_range(0, 1) ? MODE_SPARE_HI : MODE_SPARE_LO;
  endfunction

  task automatic run_random(int count, int push_pct);
    for (int n = 0; n < count; n++) begin
      send_op(random_mode(push_pct), random_word());
    end
  endtask

  // every operation but push on an empty queue, the spare codes too
  task automatic test_empty_queue();
    send_op(MODE_POP, random_word());
    send_op(MODE_CRESET, random_word());
    send_op(MODE_CADV, random_word());
    send_op(MODE_CREAD, random_word());
    send_op(MODE_REMOVE, random_word());
    send_op(MODE_SPARE_LO, random_word());
    send_op(MODE_SPARE_HI, random_word());
  endtask

  // extreme values and the cursor corner cases on a short queue
  task automatic test_cursor_cases();
    send_op(MODE_PUSH, WORD_MIN);
    send_op(MODE_PUSH, WORD_MAX);
    send_op(MODE_PUSH, '0);
    send_op(MODE_PUSH, -1);
    send_op(MODE_CRESET, '0);
    repeat (3) send_op(MODE_CADV, '0);
    // advance on the last entry stays put
    send_op(MODE_CADV, '0);
    send_op(MODE_CREAD, '0);
    // remove of the last entry invalidates the cursor
    send_op(MODE_REMOVE, '0);
    send_op(MODE_CADV, '0);
    send_op(MODE_CRESET, '0);
    send_op(MODE_CADV, '0);
    // pop with the cursor elsewhere, then with the cursor on the head
    send_op(MODE_POP, '0);
    send_op(MODE_POP, '0);
    send_op(MODE_REMOVE, '0);
  endtask

  // fill to the top, push once more, then remove the head entry through the cursor
  task automatic test_full_queue();
    while (shadow_fill < DEPTH) send_op(MODE_PUSH, random_word());
    send_op(MODE_PUSH, random_word());
    send_op(MODE_CRESET, '0);
    send_op(MODE_REMOVE, '0);
  endtask

  // receiver holds off while the sender keeps offering, then the sender waits
  task automatic test_backpressure();
    recv_hold_left = 60;
    run_random(40, 40);
    wait_drained();
  endtask

  // no idling on either side
  task automatic test_calm_stretch();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    run_random(120, 35);
    send_idle_pct = 14;
    recv_stall_pct = 14;
  endtask

  // receiver stall, set at the falling edge
  always @(negedge clk_i) begin
    if (recv_hold_left > 0) begin
      out_stall_i <= 1'b1;
      recv_hold_left = recv_hold_left - 1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin
    fqc_rsp_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no transaction outstanding");
      end else begin
        want = pending_results.pop_front();
        if (out_rsp_o.ok !== want.ok)
          report_mismatch($sformatf("ok %b, want %b", out_rsp_o.ok, want.ok));
        if (out_rsp_o.data_out !== want.data_out)
          report_mismatch($sformatf("data_out %0d, want %0d",
                                    out_rsp_o.data_out, want.data_out));
        if (out_rsp_o.fill_count !== want.fill_count)
          report_mismatch($sformatf("fill_count %0d, want %0d",
                                    out_rsp_o.fill_count, want.fill_count));
        if (out_rsp_o.cursor_ok !== want.cursor_ok)
          report_mismatch($sformatf("cursor_ok %b, want %b",
                                    out_rsp_o.cursor_ok, want.cursor_ok));
      end
    end
  end

  // test sequence
  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    test_empty_queue();
    test_cursor_cases();
    test_full_queue();
    run_random(250, 45);
    test_backpressure();
    run_random(200, 22);
    test_calm_stretch();
    run_random(150, 33);
    wait_drained();
    repeat (5) @(posedge clk_i);
    if (pending_results.size() != 0) report_mismatch("results still outstanding at the end");
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
